[rtl/sgm_path_cost_step_top_assert.svh]
// ---------------------------------------------------------------------------
// sgm_path_cost_step_top_assert.svh
// Assertion macros used by the path cost step checker.
// ---------------------------------------------------------------------------
`ifndef SGM_PATH_COST_STEP_TOP_ASSERT_SVH
`define SGM_PATH_COST_STEP_TOP_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define SGM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check the consequent in the cycle after the antecedent
`define SGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sgm_pcs_pkg.sv]
// ---------------------------------------------------------------------------
// sgm_pcs_pkg
// Widths, register indexes and sequencer states of the path cost step.
// ---------------------------------------------------------------------------
package sgm_pcs_pkg;

  localparam int COST_W     = 12;
  localparam int LCOST_W    = 8;
  localparam int GRAD_W     = 8;
  localparam int P1_W       = 8;
  localparam int P2_W       = 11;
  localparam int DISP_OUT_W = 6;
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 11;
  localparam int SMOOTH_W   = COST_W + 1;
  localparam int SUM_W      = COST_W + 2;
  localparam int DIV_CNT_W  = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [COST_W-1:0]    COST_MAX   = '1;
  localparam logic [P1_W-1:0]      P1_RESET   = 8'd8;
  localparam logic [P2_W-1:0]      P2_RESET   = 11'd64;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(P2_W - 1);

  localparam logic [CFG_AW-1:0] REG_PENALTY_SMALL = 1'd0;
  localparam logic [CFG_AW-1:0] REG_PENALTY_LARGE = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_FETCH,
    ST_CALC,
    ST_OUT
  } state_t;

endpackage

[rtl/sgm_pcs_ram.sv]
// ---------------------------------------------------------------------------
// sgm_pcs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sgm_pcs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sgm_path_cost_step_top.sv]
// ---------------------------------------------------------------------------
// sgm_path_cost_step_top
// Semi-global matching path aggregation, one disparity per item.
// ---------------------------------------------------------------------------
// Items carry one pixel's matching costs in disparity order, 0 to
// DISP_COUNT-1, and each item returns exactly one result. For the item at
// disparity 0 an 11-step restoring divider first forms the large-jump
// penalty P2/gradient for the pixel. Every item then goes through the
// read, compute and write sequence on the single-read-port cost memory,
// and the next item is taken only after its write. The prior and current
// cost vectors share one memory of 2*DISP_COUNT entries used as ping-pong
// halves; no clearing pass is needed, since the prior reads as zero after
// reset and on path start. A finished result waits in the output register
// while the next item is taken.
module sgm_path_cost_step_top
  import sgm_pcs_pkg::*;
#(
  parameter int DISP_COUNT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // local_cost, gradient
  input  logic [0:0]            in_tuser,   // path_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // disparity, path_cost, zero pad
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_DW-1:0]     cfg_wdata
);

  localparam int DW = $clog2(DISP_COUNT);
  localparam int AW = DW + 1;
  localparam logic [DW-1:0] D_LAST = DW'(DISP_COUNT - 1);

  state_t state_r, state_nxt;

  logic [P1_W-1:0]      p1_r;
  logic [P2_W-1:0]      p2_r;
  logic [DW-1:0]        d_r;
  logic                 bank_r;
  logic                 prior_zero_r;
  logic [LCOST_W-1:0]   cost_r;
  logic [GRAD_W-1:0]    grad_r;
  logic [GRAD_W-1:0]    rem_r;
  logic [P2_W-1:0]      quo_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic [COST_W-1:0]    lpen_r;
  logic [COST_W-1:0]    w_prev_r;
  logic [COST_W-1:0]    w_cur_r;
  logic [SMOOTH_W-1:0]  smooth_r;
  logic [COST_W-1:0]    prior_min_r;
  logic [COST_W-1:0]    run_min_r;
  logic                 out_valid_r;
  logic [DISP_OUT_W-1:0] out_disp_r;
  logic [COST_W-1:0]    out_cost_r;
  logic                 out_last_r;

  logic                 in_fire;
  logic                 out_room;
  logic                 first_d;
  logic                 last_d;
  logic [DW-1:0]        d_inc;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [COST_W-1:0]    rd_data;
  logic [COST_W-1:0]    rd_prior;
  logic [COST_W-1:0]    pmin;
  logic [GRAD_W:0]      div_tmp;
  logic                 div_ge;
  logic [GRAD_W:0]      div_sub;
  logic [P2_W-1:0]      jump;
  logic [COST_W-1:0]    lpen_nxt;
  logic [SMOOTH_W-1:0]  cand_mid;
  logic [SMOOTH_W-1:0]  cand_ctr;
  logic [SMOOTH_W-1:0]  cand_lo;
  logic [SMOOTH_W-1:0]  cand_hi;
  logic [SMOOTH_W-1:0]  min_a;
  logic [SMOOTH_W-1:0]  min_b;
  logic [SMOOTH_W-1:0]  smooth_nxt;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     norm;
  logic [COST_W-1:0]    value;
  logic [COST_W-1:0]    run_min_nxt;

  assign in_fire  = in_tvalid && in_tready;
  assign out_room = !out_valid_r || out_tready;
  assign first_d  = (d_r == '0);
  assign last_d   = (d_r == D_LAST);
  assign d_inc    = d_r + DW'(1);

  assign rd_prior = prior_zero_r ? '0 : rd_data;
  assign pmin     = prior_zero_r ? '0 : prior_min_r;

  // restoring divider step
  assign div_tmp = {rem_r, quo_r[P2_W-1]};
  assign div_ge  = (div_tmp >= {1'b0, grad_r});
  assign div_sub = div_tmp - {1'b0, grad_r};

  assign jump     = (grad_r == '0) ? p2_r : quo_r;
  assign lpen_nxt = (jump > P2_W'(p1_r)) ? COST_W'(jump) : COST_W'(p1_r);

  // smoothing candidates
  assign cand_mid = SMOOTH_W'(pmin) + SMOOTH_W'(lpen_r);
  assign cand_ctr = SMOOTH_W'(w_cur_r);
  assign cand_lo  = first_d ? '1 : SMOOTH_W'(w_prev_r) + SMOOTH_W'(p1_r);
  assign cand_hi  = last_d  ? '1 : SMOOTH_W'(rd_prior) + SMOOTH_W'(p1_r);
  assign min_a    = (cand_mid < cand_ctr) ? cand_mid : cand_ctr;
  assign min_b    = (cand_lo < cand_hi) ? cand_lo : cand_hi;
  assign smooth_nxt = (min_a < min_b) ? min_a : min_b;

  assign sum   = SUM_W'(smooth_r) + SUM_W'(cost_r);
  assign norm  = (sum >= SUM_W'(pmin)) ? sum - SUM_W'(pmin) : '0;
  assign value = (norm > SUM_W'(COST_MAX)) ? COST_MAX : norm[COST_W-1:0];
  assign run_min_nxt = (value < run_min_r) ? value : run_min_r;

  assign wr_addr = {bank_r, d_r};

  sgm_pcs_ram #(
    .WIDTH(COST_W),
    .DEPTH(2 * DISP_COUNT)
  ) u_cost_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(value),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = first_d ? ST_DIV : ST_FETCH;
        end
      end
      ST_DIV: begin
        if (dcnt_r == DIV_LAST) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD:  state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_room) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = {~bank_r, d_inc};
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_LOAD:  rd_addr   = {~bank_r, {DW{1'b0}}};
      ST_OUT:   wr_en     = out_room;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      p1_r         <= P1_RESET;
      p2_r         <= P2_RESET;
      d_r          <= '0;
      bank_r       <= 1'b0;
      prior_zero_r <= 1'b1;
      prior_min_r  <= '0;
      run_min_r    <= COST_MAX;
      out_valid_r  <= 1'b0;
      dcnt_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PENALTY_SMALL: p1_r <= cfg_wdata[P1_W-1:0];
          REG_PENALTY_LARGE: p2_r <= cfg_wdata[P2_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        cost_r <= in_tdata[LCOST_W-1:0];
        grad_r <= in_tdata[LCOST_W +: GRAD_W];
        rem_r  <= '0;
        quo_r  <= p2_r;
        dcnt_r <= '0;
        if (first_d && in_tuser[0]) begin
          prior_zero_r <= 1'b1;
        end
      end

      if (state_r == ST_DIV) begin
        rem_r  <= div_ge ? div_sub[GRAD_W-1:0] : div_tmp[GRAD_W-1:0];
        quo_r  <= {quo_r[P2_W-2:0], div_ge};
        dcnt_r <= dcnt_r + DIV_CNT_W'(1);
      end

      if (state_r == ST_LOAD) begin
        lpen_r <= lpen_nxt;
      end

      if (state_r == ST_FETCH && first_d) begin
        w_cur_r <= rd_prior;
      end

      if (state_r == ST_CALC) begin
        smooth_r <= smooth_nxt;
        w_prev_r <= w_cur_r;
        w_cur_r  <= rd_prior;
      end

      if (state_r == ST_OUT && out_room) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == ST_OUT && out_room) begin
        out_disp_r  <= DISP_OUT_W'({{DISP_OUT_W{1'b0}}, d_r});
        out_cost_r  <= value;
        out_last_r  <= last_d;
        if (last_d) begin
          bank_r       <= ~bank_r;
          prior_min_r  <= run_min_nxt;
          run_min_r    <= COST_MAX;
          prior_zero_r <= 1'b0;
          d_r          <= '0;
        end else begin
          run_min_r <= run_min_nxt;
          d_r       <= d_inc;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - DISP_OUT_W - COST_W){1'b0}}, out_cost_r, out_disp_r};
  assign out_tlast  = out_last_r;

endmodule

[rtl/sgm_pcs_chk.sv]
// ---------------------------------------------------------------------------
// sgm_pcs_chk
// Port-level checks of the path cost step, bound to the top level.
// ---------------------------------------------------------------------------
`include "sgm_path_cost_step_top_assert.svh"

module sgm_pcs_chk
  import sgm_pcs_pkg::*;
#(
  parameter int DISP_COUNT = 64
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,  // disparity, path_cost, zero pad
  input logic                  out_tlast
);

  localparam logic [DISP_OUT_W-1:0] LAST_DISP = DISP_OUT_W'((DISP_COUNT - 1) % 64);
  localparam int PAD_LO = DISP_OUT_W + COST_W;

  `SGM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")
  `SGM_ASSERT_NOW(a_idle_after_reset, $past(!rst_n), !out_tvalid,
    "result shown right after reset")
  `SGM_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready,
    "item accepted while the previous one is at work")
  `SGM_ASSERT_NOW(a_last_disp, out_tvalid && out_tlast,
    out_tdata[DISP_OUT_W-1:0] == LAST_DISP, "last flag on wrong disparity")
  `SGM_ASSERT_NOW(a_pad_zero, out_tvalid,
    out_tdata[OUT_DATA_W-1:PAD_LO] == '0, "nonzero pad bits in result")

endmodule

bind sgm_path_cost_step_top sgm_pcs_chk #(.DISP_COUNT(DISP_COUNT)) u_sgm_pcs_chk (.*);

[bench/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the path cost step of semi-global matching.
// ---------------------------------------------------------------------------
// Streams whole pixels of matching costs, one disparity per item, under
// several penalty settings, with bursty input and a stalling receiver. An
// in-bench model of the path aggregation predicts each result. A scoreboard
// compares every accepted result with the oldest prediction.
module tb;
  import sgm_pcs_pkg::*;

  localparam int DISP_COUNT = 64;
  localparam int NUM_PIXELS = 16;

  typedef struct {
    logic [DISP_OUT_W-1:0] disparity;
    logic [COST_W-1:0]     path_cost;
    logic                  last_disparity;
  } path_result_t;

  class path_cost_board;
    int unsigned  p_small;
    int unsigned  p_large;
    int unsigned  prior_cost [DISP_COUNT];
    int unsigned  fresh_cost [DISP_COUNT];
    int unsigned  prior_min;
    int unsigned  run_min;
    int unsigned  disp_idx;
    int unsigned  jump_pen;
    path_result_t due_costs [$];
    int           mismatches;

    function new();
      p_small    = P1_RESET;
      p_large    = P2_RESET;
      foreach (prior_cost[i]) begin
        prior_cost[i] = 0;
        fresh_cost[i] = 0;
      end
      prior_min  = 0;
      run_min    = COST_MAX;
      disp_idx   = 0;
      jump_pen   = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      if (addr == REG_PENALTY_SMALL) begin
        p_small = data[P1_W-1:0];
      end else if (addr == REG_PENALTY_LARGE) begin
        p_large = data[P2_W-1:0];
      end
    endfunction

    function void note_item(logic [LCOST_W-1:0] cost, logic [GRAD_W-1:0] grad,
                            logic start);
      int unsigned  d;
      int unsigned  jump;
      int unsigned  smooth;
      int unsigned  value;
      path_result_t r;
      d = disp_idx;
      if (d >= DISP_COUNT) d = 0;
      if (d == 0) begin
        jump = (grad != 0) ? p_large / grad : p_large;
        jump_pen = ((jump > p_small) ? jump : p_small) & int'(COST_MAX);
        if (start) begin
          foreach (prior_cost[i]) prior_cost[i] = 0;
          prior_min = 0;
        end
      end
      smooth = prior_min + jump_pen;
      if (prior_cost[d] < smooth) smooth = prior_cost[d];
      if (d > 0 && prior_cost[d-1] + p_small < smooth) smooth = prior_cost[d-1] + p_small;
      if (d + 1 < DISP_COUNT && prior_cost[d+1] + p_small < smooth)
        smooth = prior_cost[d+1] + p_small;
      value = cost + smooth;
      value = (value >= prior_min) ? value - prior_min : 0;
      if (value > COST_MAX) value = COST_MAX;
      fresh_cost[d] = value;
      if (value < run_min) run_min = value;
      r.disparity      = d[DISP_OUT_W-1:0];
      r.path_cost      = value[COST_W-1:0];
      r.last_disparity = (d + 1 >= DISP_COUNT);
      if (r.last_disparity) begin
        prior_cost = fresh_cost;
        prior_min  = run_min;
        run_min    = COST_MAX;
        disp_idx   = 0;
      end else begin
        disp_idx = d + 1;
      end
      due_costs.push_back(r);
    endfunction

    function void check_result(path_result_t got);
      path_result_t want;
      if (due_costs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: disp %0d cost %0d last %0d",
                   got.disparity, got.path_cost, got.last_disparity);
        return;
      end
      want = due_costs.pop_front();
      if (got.disparity !== want.disparity || got.path_cost !== want.path_cost ||
          got.last_disparity !== want.last_disparity) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected disp %0d cost %0d last %0d, got disp %0d cost %0d last %0d",
                   want.disparity, want.path_cost, want.last_disparity,
                   got.disparity, got.path_cost, got.last_disparity);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // local_cost, gradient
  logic [0:0]            in_tuser   = '0;  // path_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // disparity, path_cost, zero pad
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr   = '0;
  logic [CFG_DW-1:0]     cfg_wdata  = '0;

  path_cost_board board;
  int             burst_left = 0;
  int unsigned    stall_tick = 0;

  sgm_path_cost_step_top #(
    .DISP_COUNT(DISP_COUNT)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    path_result_t got;
    if (rst_n && cfg_we) board.write_reg(cfg_addr, cfg_wdata);
    if (rst_n && in_tvalid && in_tready)
      board.note_item(in_tdata[LCOST_W-1:0], in_tdata[LCOST_W +: GRAD_W], in_tuser[0]);
    if (rst_n && out_tvalid && out_tready) begin
      got.disparity      = out_tdata[DISP_OUT_W-1:0];
      got.path_cost      = out_tdata[DISP_OUT_W +: COST_W];
      got.last_disparity = out_tlast;
      board.check_result(got);
    end
  end

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick >> 8) % 4)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= ((stall_tick % 7) < 5);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_item(input logic [LCOST_W-1:0] cost, input logic [GRAD_W-1:0] grad,
                           input logic start);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {grad, cost};
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (board.due_costs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_penalties(input int unsigned small_pen, input int unsigned large_pen);
    wait_results_done();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PENALTY_SMALL;
    cfg_wdata <= CFG_DW'(small_pen);
    @(negedge clk);
    cfg_addr  <= REG_PENALTY_LARGE;
    cfg_wdata <= CFG_DW'(large_pen);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [GRAD_W-1:0]  grad;
    logic               start;
    logic [LCOST_W-1:0] cost;
    int                 mode;
    int                 centre;
    int                 slope;
    int                 span;
    int                 level;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PIXELS; p++) begin
      case (p)
        3:  write_penalties(0, 0);
        6:  write_penalties(255, 2047);
        9:  write_penalties(0, 2047);
        11: write_penalties(255, 0);
        13: write_penalties($urandom_range(0, 255), $urandom_range(0, 2047));
        15: write_penalties(8, 64);
        default: ;
      endcase
      case (p)
        0:       grad = 8'd0;
        1:       grad = 8'd1;
        2:       grad = 8'd255;
        3:       grad = 8'd0;
        default: grad = ($urandom_range(0, 3) == 0) ? 8'd0 :
                        GRAD_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 16)
                                                             : $urandom_range(0, 255));
      endcase
      start  = (p == 0 || p == 5) ? 1'b1 : ($urandom_range(0, 3) == 0);
      mode   = (p == 0) ? 1 : $urandom_range(0, 3);
      centre = $urandom_range(0, DISP_COUNT - 1);
      slope  = $urandom_range(1, 16);
      level  = $urandom_range(0, 1) ? 255 : 0;
      for (int d = 0; d < DISP_COUNT; d++) begin
        span = (d > centre) ? d - centre : centre - d;
        case (mode)
          0: cost = LCOST_W'($urandom_range(0, 255));
          1: cost = (d % 2 == 0) ? 8'd0 : 8'd255;
          2: cost = (span * slope + $urandom_range(0, 7) > 255) ? 8'd255
                    : LCOST_W'(span * slope + $urandom_range(0, 7));
          default: cost = ($urandom_range(0, 15) == 0) ? LCOST_W'($urandom_range(0, 255))
                                                       : LCOST_W'(level);
        endcase
        if (p == 7 && d == 30) wait_results_done();
        if (d == 0) send_item(cost, grad, start);
        else send_item(cost, GRAD_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    wait_results_done();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.due_costs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
